### hdl/signed_int_to_decimal_ascii_unit_assert.svh
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit assertion macros
// shared helpers for concurrent checks in the conversion unit
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// property must hold at every edge outside reset
`define SITOA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define SITOA_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hdl/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// types and constants of the signed integer to decimal text unit
// ----------------------------------------------------------------------------
package sitoa_pkg;

   localparam int MagWidth  = 32;
   localparam int NumDigits = 10;
   localparam int BcdWidth  = 4 * NumDigits;
   localparam int CharWidth = 7;
   localparam int CntWidth  = $clog2(MagWidth);
   localparam int LeftWidth = $clog2(NumDigits + 1);

   localparam logic [CntWidth-1:0]  CntLast   = CntWidth'(MagWidth - 1);
   localparam logic [LeftWidth-1:0] LeftFull  = LeftWidth'(NumDigits);
   localparam logic [LeftWidth-1:0] LeftOne   = LeftWidth'(1);
   localparam logic [CharWidth-1:0] CharMinus = 7'd45;
   localparam logic [CharWidth-1:0] CharZero  = 7'd48;
   localparam logic [CharWidth-1:0] CharNine  = 7'd57;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_SKIP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic conv_step;
      logic digit_step;
   } bcd_ctl_type;

endpackage

### hdl/sitoa_bcd.sv
// ----------------------------------------------------------------------------
// sitoa_bcd
// bit-serial binary to bcd shifter with digit-wide readout
// ----------------------------------------------------------------------------
module sitoa_bcd (
   input  logic                                clock,
   input  sitoa_pkg::bcd_ctl_type              ctl,
   input  logic [sitoa_pkg::MagWidth-1:0]      load_mag,
   output logic [3:0]                          top_digit
);
   import sitoa_pkg::*;

   logic [MagWidth-1:0] mag_ff, mag_in;
   logic [BcdWidth-1:0] bcd_ff, bcd_in, bcd_adj;

   // add-3 correction on every digit before the shift
   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      priority if (ctl.load) begin
         mag_in = load_mag;
         bcd_in = '0;
      end else if (ctl.conv_step) begin
         mag_in = {mag_ff[MagWidth-2:0], 1'b0};
         bcd_in = {bcd_adj[BcdWidth-2:0], mag_ff[MagWidth-1]};
      end else if (ctl.digit_step) begin
         bcd_in = {bcd_ff[BcdWidth-5:0], 4'h0};
      end else begin
         // hold
         bcd_in = bcd_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BcdWidth-1 -: 4];

endmodule

### hdl/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// signed 32-bit integer to decimal ascii text, one character per beat
// ----------------------------------------------------------------------------
// operation: after the input beat the magnitude is shifted bit-serially into bcd,
// then leading zero digits are dropped (up to 9) before the first digit beat
// for a negative value a minus sign goes out ahead of the digits
// a new input beat is taken only in idle, once the last digit of the previous item
// has been loaded into the result register; a result side stall holds each beat
// reset: synchronous, returns to idle and drops any pending result beat
`include "signed_int_to_decimal_ascii_unit_assert.svh"

module signed_int_to_decimal_ascii_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // char_code[6:0], zero[7]
   output logic        rsp_tlast    // is_last
);
   import sitoa_pkg::*;

   state_type              state_ff, state_in;
   logic [CntWidth-1:0]    cnt_ff, cnt_in;
   logic [LeftWidth-1:0]   left_ff, left_in;
   logic                   neg_ff, neg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]   rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   bcd_ctl_type            ctl;
   logic [3:0]             top_digit;
   logic [MagWidth-1:0]    load_mag;
   logic                   req_fire;
   logic                   slot_free;
   logic                   load_char;
   logic [CharWidth-1:0]   char_val;
   logic                   char_last;

   assign req_fire  = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign load_mag  = req_tdata[MagWidth-1] ? MagWidth'(-req_tdata) : req_tdata;

   sitoa_bcd u_bcd (
      .clock     (clock),
      .ctl       (ctl),
      .load_mag  (load_mag),
      .top_digit (top_digit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (cnt_ff == CntLast) state_in = neg_ff ? ST_SIGN : ST_SKIP;
         end
         ST_SIGN: begin
            if (slot_free) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!(top_digit == 4'd0 && left_ff > LeftOne)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free && left_ff == LeftOne) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_tready     = 1'b0;
      ctl            = '0;
      load_char      = 1'b0;
      char_val       = CharZero + {3'b000, top_digit};
      char_last      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ctl.load   = req_fire;
         end
         ST_CONV: begin
            ctl.conv_step = 1'b1;
         end
         ST_SIGN: begin
            load_char = slot_free;
            char_val  = CharMinus;
         end
         ST_SKIP: begin
            ctl.digit_step = (top_digit == 4'd0) && (left_ff > LeftOne);
         end
         ST_EMIT: begin
            load_char      = slot_free;
            char_last      = (left_ff == LeftOne);
            ctl.digit_step = slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in  = cnt_ff;
      left_in = left_ff;
      neg_in  = neg_ff;
      if (ctl.load) begin
         cnt_in  = '0;
         left_in = LeftFull;
         neg_in  = req_tdata[MagWidth-1];
      end else begin
         if (ctl.conv_step) cnt_in = cnt_ff + 1'b1;
         if (ctl.digit_step) left_in = left_ff - 1'b1;
      end
      rsp_char_in = load_char ? char_val : rsp_char_ff;
      rsp_last_in = load_char ? char_last : rsp_last_ff;
      if (load_char) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         left_ff      <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         left_ff      <= left_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   `SITOA_ASSERT(a_accept_starts_conv, clock, reset,
      req_fire |=> (state_ff == ST_CONV && cnt_ff == '0 && left_ff == LeftFull),
      "accepted beat did not start the conversion")
   `SITOA_ASSERT(a_conv_exit, clock, reset,
      (state_ff == ST_CONV && cnt_ff == CntLast)
         |=> (state_ff == ST_SIGN || state_ff == ST_SKIP),
      "conversion loop did not end after the last bit")
   `SITOA_NEVER(a_left_nonzero, clock, reset,
      (state_ff == ST_SKIP || state_ff == ST_EMIT) && left_ff == '0,
      "digit counter ran out during readout")
   `SITOA_NEVER(a_char_range, clock, reset,
      rsp_valid_ff && !(rsp_char_ff == CharMinus
         || (rsp_char_ff >= CharZero && rsp_char_ff <= CharNine)),
      "result character is neither a minus sign nor a digit")

endmodule
